// ===== src/vma_pkg.sv =====
// shared types, constants and helpers for the velocity moment accumulator
package vma_pkg;

    localparam int unsigned FRAC_BITS   = 16;
    localparam int unsigned DV_FRAC     = 24;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [31:0] DV_RESET  = 32'h0100_0000;
    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN = 32'h8000_0000;
    localparam logic [30:0] U31_MAX   = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_N,
        ST_MUL_NU,
        ST_MUL_S2,
        ST_DIV_U,
        ST_DIV_R,
        ST_MUL_UU,
        ST_FIN
    } t_state;

    // one finished row of sums on its way to the back end
    typedef struct packed {
        logic signed [63:0] s0;
        logic signed [63:0] s1;
        logic signed [63:0] s2;
        logic               ovf;
    } t_sums;

    typedef struct packed {
        logic signed [63:0] sum;
        logic               sat;
    } t_sadd;

    typedef struct packed {
        logic        start;
        logic        sel_dv;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    // magnitude is at most 2^63-1 after saturation
    typedef struct packed {
        logic        done;
        logic        over;
        logic [63:0] mag;
    } t_unit_rsp;

    function automatic t_sadd add_sat(input logic signed [63:0] a,
                                      input logic signed [63:0] b);
        logic signed [64:0] s;
        t_sadd              r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            r.sat = 1'b1;
            r.sum = s[64] ? INT64_MIN : INT64_MAX;
        end else begin
            r.sat = 1'b0;
            r.sum = s[63:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] x);
        return x[63] ? (64'd0 - 64'(x)) : 64'(x);
    endfunction

    function automatic logic [63:0] apply_sign(input logic [63:0] mag, input logic neg);
        return neg ? (64'd0 - mag) : mag;
    endfunction

endpackage

// ===== src/vma_in_if.sv =====
// sample channel: one distribution sample per transfer
interface vma_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_value;
    logic signed [31:0] node_velocity;
    logic               row_end;

    modport source (output valid, sample_value, node_velocity, row_end, input ready);
    modport sink   (input valid, sample_value, node_velocity, row_end, output ready);
endinterface

// ===== src/vma_out_if.sv =====
// moment channel: one result per row
interface vma_out_if;
    logic               valid;
    logic               ready;
    logic        [30:0] density;
    logic signed [31:0] momentum;
    logic        [30:0] temperature;
    logic               saturated;

    modport source (output valid, density, momentum, temperature, saturated, input ready);
    modport sink   (input valid, density, momentum, temperature, saturated, output ready);
endinterface

// ===== src/vma_front.sv =====
// front end: per-sample products and saturating moment sums
module vma_front #(
    parameter int unsigned FRAC_BITS = vma_pkg::FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    vma_in_if.sink          i_in,
    input  logic            i_q_ready,
    output logic            o_q_push,
    output vma_pkg::t_sums  o_q_data
);

    logic               w_en;
    logic [31:0]        w_fmag;
    logic [31:0]        w_vmag;

    logic               r_s1_valid;
    logic [63:0]        r_s1_prod;
    logic               r_s1_neg1;
    logic [31:0]        r_s1_vmag;
    logic               r_s1_vneg;
    logic signed [63:0] r_s1_f;
    logic               r_s1_last;

    logic [63:0]        w_t1mag;
    logic               r_s2_valid;
    logic signed [63:0] r_s2_t1;
    logic [63:0]        r_s2_lo;
    logic [63:0]        r_s2_hi;
    logic               r_s2_neg2;
    logic signed [63:0] r_s2_f;
    logic               r_s2_last;

    logic [95:0]        w_full;
    logic [95:0]        w_sh;
    logic               w_over;
    logic [63:0]        w_t2mag;
    logic               r_s3_valid;
    logic signed [63:0] r_s3_t1;
    logic signed [63:0] r_s3_t2;
    logic               r_s3_sat;
    logic signed [63:0] r_s3_f;
    logic               r_s3_last;

    logic signed [63:0] r_sum0;
    logic signed [63:0] r_sum1;
    logic signed [63:0] r_sum2;
    logic               r_ovf;
    vma_pkg::t_sadd     w_a0;
    vma_pkg::t_sadd     w_a1;
    vma_pkg::t_sadd     w_a2;
    logic               w_ovf;

    // the whole pipe holds when a finished row cannot enter the queue
    assign w_en       = !(r_s3_valid && r_s3_last && !i_q_ready);
    assign i_in.ready = w_en;

    assign w_fmag = i_in.sample_value[31]  ? (32'd0 - 32'(i_in.sample_value))
                                           : 32'(i_in.sample_value);
    assign w_vmag = i_in.node_velocity[31] ? (32'd0 - 32'(i_in.node_velocity))
                                           : 32'(i_in.node_velocity);

    assign w_t1mag = r_s1_prod >> FRAC_BITS;

    assign w_full  = {r_s2_hi, 32'd0} + {32'd0, r_s2_lo};
    assign w_sh    = w_full >> FRAC_BITS;
    assign w_over  = |w_sh[95:63];
    assign w_t2mag = w_over ? vma_pkg::INT64_MAX : {1'b0, w_sh[62:0]};

    assign w_a0  = vma_pkg::add_sat(r_sum0, r_s3_f);
    assign w_a1  = vma_pkg::add_sat(r_sum1, r_s3_t1);
    assign w_a2  = vma_pkg::add_sat(r_sum2, r_s3_t2);
    assign w_ovf = r_ovf | r_s3_sat | w_a0.sat | w_a1.sat | w_a2.sat;

    assign o_q_push     = w_en && r_s3_valid && r_s3_last;
    assign o_q_data.s0  = w_a0.sum;
    assign o_q_data.s1  = w_a1.sum;
    assign o_q_data.s2  = w_a2.sum;
    assign o_q_data.ovf = w_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_sum0     <= '0;
            r_sum1     <= '0;
            r_sum2     <= '0;
            r_ovf      <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_in.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            if (r_s3_valid) begin
                if (r_s3_last) begin
                    r_sum0 <= '0;
                    r_sum1 <= '0;
                    r_sum2 <= '0;
                    r_ovf  <= 1'b0;
                end else begin
                    r_sum0 <= w_a0.sum;
                    r_sum1 <= w_a1.sum;
                    r_sum2 <= w_a2.sum;
                    r_ovf  <= w_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_prod <= 64'(w_fmag) * 64'(w_vmag);
            r_s1_neg1 <= i_in.sample_value[31] ^ i_in.node_velocity[31];
            r_s1_vmag <= w_vmag;
            r_s1_vneg <= i_in.node_velocity[31];
            r_s1_f    <= 64'(i_in.sample_value);
            r_s1_last <= i_in.row_end;

            r_s2_t1   <= vma_pkg::apply_sign(w_t1mag, r_s1_neg1);
            r_s2_lo   <= 64'(w_t1mag[31:0]) * 64'(r_s1_vmag);
            r_s2_hi   <= 64'(w_t1mag[63:32]) * 64'(r_s1_vmag);
            r_s2_neg2 <= r_s1_neg1 ^ r_s1_vneg;
            r_s2_f    <= r_s1_f;
            r_s2_last <= r_s1_last;

            r_s3_t1   <= r_s2_t1;
            r_s3_t2   <= vma_pkg::apply_sign(w_t2mag, r_s2_neg2);
            r_s3_sat  <= w_over;
            r_s3_f    <= r_s2_f;
            r_s3_last <= r_s2_last;
        end
    end

endmodule

// ===== src/vma_queue.sv =====
// small fifo of finished row sums between front and back end
module vma_queue #(
    parameter int unsigned DEPTH = vma_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vma_pkg::t_sums  i_data,
    output logic            o_ready,
    output logic            o_valid,
    output vma_pkg::t_sums  o_data,
    input  logic            i_pop
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    vma_pkg::t_sums r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           w_push;
    logic           w_pop;

    assign o_ready = r_count != CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/vma_mul.sv =====
// 64x64 magnitude multiplier, four 32x32 partial products, scaled and saturated
module vma_mul #(
    parameter int unsigned FRAC_BITS = vma_pkg::FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vma_pkg::t_mul_req  i_req,
    output vma_pkg::t_unit_rsp o_rsp
);

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic         r_sel;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_pvalid;
    logic [63:0]  r_p;
    logic [1:0]   r_psh;
    logic [127:0] r_acc;
    logic         r_done;
    logic [31:0]  w_ap;
    logic [31:0]  w_bp;
    logic [127:0] w_sh;
    logic         w_over;

    assign w_ap = r_cnt[0] ? r_a[63:32] : r_a[31:0];
    assign w_bp = r_cnt[1] ? r_b[63:32] : r_b[31:0];

    assign w_sh   = r_sel ? (r_acc >> vma_pkg::DV_FRAC) : (r_acc >> FRAC_BITS);
    assign w_over = |w_sh[127:63];

    assign o_rsp.done = r_done;
    assign o_rsp.over = w_over;
    assign o_rsp.mag  = w_over ? vma_pkg::INT64_MAX : {1'b0, w_sh[62:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pvalid <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy   <= 1'b1;
                r_pvalid <= 1'b0;
                r_cnt    <= '0;
            end else if (r_busy) begin
                r_pvalid <= !r_cnt[2];
                if (!r_cnt[2]) begin
                    r_cnt <= r_cnt + 3'd1;
                end else if (!r_pvalid) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial product registered before it is added in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_sel <= i_req.sel_dv;
            r_acc <= '0;
        end else begin
            r_p   <= 64'(w_ap) * 64'(w_bp);
            r_psh <= {1'b0, r_cnt[0]} + {1'b0, r_cnt[1]};
            if (r_busy && r_pvalid) begin
                r_acc <= r_acc + ({64'd0, r_p} << {r_psh, 5'd0});
            end
        end
    end

endmodule

// ===== src/vma_div.sv =====
// restoring divider, one quotient bit per cycle, dividend scaled by FRAC_BITS
module vma_div #(
    parameter int unsigned FRAC_BITS = vma_pkg::FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vma_pkg::t_div_req  i_req,
    output vma_pkg::t_unit_rsp o_rsp
);

    localparam int unsigned W  = 64 + FRAC_BITS;
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_dvd;
    logic [W-1:0]  r_q;
    logic [63:0]   r_rem;
    logic [63:0]   r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [64:0]   w_trial;
    logic          w_ge;
    logic [64:0]   w_diff;
    logic          w_over;

    assign w_trial = {r_rem, r_dvd[W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_over  = |r_q[W-1:63];

    assign o_rsp.done = r_done;
    assign o_rsp.over = w_over;
    assign o_rsp.mag  = w_over ? vma_pkg::INT64_MAX : {1'b0, r_q[62:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so 64 bits hold it
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= {i_req.num, FRAC_BITS'(0)};
            r_q   <= '0;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[63:0] : w_trial[63:0];
            r_q   <= {r_q[W-2:0], w_ge};
            r_dvd <= r_dvd << 1;
        end
    end

endmodule

// ===== src/vma_back.sv =====
// back end: per-row scaling, division, temperature and output register
module vma_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_dv,
    input  logic               i_q_valid,
    input  vma_pkg::t_sums     i_q_data,
    output logic               o_q_pop,
    output vma_pkg::t_mul_req  o_mul_req,
    input  vma_pkg::t_unit_rsp i_mul_rsp,
    output vma_pkg::t_div_req  o_div_req,
    input  vma_pkg::t_unit_rsp i_div_rsp,
    vma_out_if.source          o_out
);

    vma_pkg::t_state    r_state;
    vma_pkg::t_state    n_state;

    logic signed [63:0] r_s0;
    logic signed [63:0] r_s1;
    logic signed [63:0] r_s2;
    logic               r_sat;
    logic [63:0]        r_n;
    logic signed [63:0] r_nu;
    logic signed [63:0] r_s2v;
    logic signed [63:0] r_u;
    logic signed [63:0] r_ratio;
    logic [63:0]        r_uu;

    logic               r_out_valid;
    logic [30:0]        r_density;
    logic signed [31:0] r_momentum;
    logic [30:0]        r_temperature;
    logic               r_saturated;

    logic               w_load;
    vma_pkg::t_sadd     w_diff;
    logic signed [63:0] w_temp;
    logic [30:0]        w_dens;
    logic [30:0]        w_tout;
    logic [31:0]        w_mom;
    logic               w_fin_sat;

    assign o_out.valid       = r_out_valid;
    assign o_out.density     = r_density;
    assign o_out.momentum    = r_momentum;
    assign o_out.temperature = r_temperature;
    assign o_out.saturated   = r_saturated;

    always_comb begin
        w_diff = vma_pkg::add_sat(r_ratio, 64'd0 - r_uu);
        w_temp = (w_diff.sum < 64'sd1) ? 64'sd1 : w_diff.sum;
        w_fin_sat = r_sat | w_diff.sat;
        if (r_n > 64'(vma_pkg::U31_MAX)) begin
            w_dens    = vma_pkg::U31_MAX;
            w_fin_sat = 1'b1;
        end else begin
            w_dens = r_n[30:0];
        end
        if (w_temp > $signed(64'(vma_pkg::U31_MAX))) begin
            w_tout    = vma_pkg::U31_MAX;
            w_fin_sat = 1'b1;
        end else begin
            w_tout = w_temp[30:0];
        end
        if (r_nu > $signed(64'(vma_pkg::INT32_MAX))) begin
            w_mom     = vma_pkg::INT32_MAX;
            w_fin_sat = 1'b1;
        end else if (r_nu < -$signed(64'h8000_0000)) begin
            w_mom     = vma_pkg::INT32_MIN;
            w_fin_sat = 1'b1;
        end else begin
            w_mom = r_nu[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vma_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_q_pop          = 1'b0;
        w_load           = 1'b0;
        o_mul_req.start  = 1'b0;
        o_mul_req.sel_dv = 1'b1;
        o_mul_req.a      = vma_pkg::abs64(r_s1);
        o_mul_req.b      = {32'd0, i_dv};
        o_div_req.start  = 1'b0;
        o_div_req.num    = vma_pkg::abs64(r_nu);
        o_div_req.den    = r_n;
        case (r_state)
            vma_pkg::ST_IDLE: begin
                o_mul_req.a = vma_pkg::abs64(i_q_data.s0);
                if (i_q_valid) begin
                    o_q_pop         = 1'b1;
                    o_mul_req.start = 1'b1;
                    n_state         = vma_pkg::ST_MUL_N;
                end
            end
            vma_pkg::ST_MUL_N: begin
                if (i_mul_rsp.done) begin
                    o_mul_req.start = 1'b1;
                    n_state         = vma_pkg::ST_MUL_NU;
                end
            end
            vma_pkg::ST_MUL_NU: begin
                o_mul_req.a = vma_pkg::abs64(r_s2);
                if (i_mul_rsp.done) begin
                    o_mul_req.start = 1'b1;
                    n_state         = vma_pkg::ST_MUL_S2;
                end
            end
            vma_pkg::ST_MUL_S2: begin
                if (i_mul_rsp.done) begin
                    o_div_req.start = 1'b1;
                    n_state         = vma_pkg::ST_DIV_U;
                end
            end
            vma_pkg::ST_DIV_U: begin
                o_div_req.num = vma_pkg::abs64(r_s2v);
                if (i_div_rsp.done) begin
                    o_div_req.start = 1'b1;
                    n_state         = vma_pkg::ST_DIV_R;
                end
            end
            vma_pkg::ST_DIV_R: begin
                o_mul_req.sel_dv = 1'b0;
                o_mul_req.a      = vma_pkg::abs64(r_u);
                o_mul_req.b      = vma_pkg::abs64(r_u);
                if (i_div_rsp.done) begin
                    o_mul_req.start = 1'b1;
                    n_state         = vma_pkg::ST_MUL_UU;
                end
            end
            vma_pkg::ST_MUL_UU: begin
                if (i_mul_rsp.done) begin
                    n_state = vma_pkg::ST_FIN;
                end
            end
            vma_pkg::ST_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load  = 1'b1;
                    n_state = vma_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s0  <= i_q_data.s0;
            r_s1  <= i_q_data.s1;
            r_s2  <= i_q_data.s2;
            r_sat <= i_q_data.ovf;
        end
        if (i_mul_rsp.done) begin
            r_sat <= r_sat | i_mul_rsp.over;
        end
        if (i_div_rsp.done) begin
            r_sat <= r_sat | i_div_rsp.over;
        end
        case (r_state)
            vma_pkg::ST_MUL_N: begin
                // non-positive density is taken as one lsb
                if (i_mul_rsp.done) begin
                    r_n <= (r_s0[63] || i_mul_rsp.mag == '0) ? 64'd1 : i_mul_rsp.mag;
                end
            end
            vma_pkg::ST_MUL_NU: begin
                if (i_mul_rsp.done) begin
                    r_nu <= vma_pkg::apply_sign(i_mul_rsp.mag, r_s1[63]);
                end
            end
            vma_pkg::ST_MUL_S2: begin
                if (i_mul_rsp.done) begin
                    r_s2v <= vma_pkg::apply_sign(i_mul_rsp.mag, r_s2[63]);
                end
            end
            vma_pkg::ST_DIV_U: begin
                if (i_div_rsp.done) begin
                    r_u <= vma_pkg::apply_sign(i_div_rsp.mag, r_nu[63]);
                end
            end
            vma_pkg::ST_DIV_R: begin
                if (i_div_rsp.done) begin
                    r_ratio <= vma_pkg::apply_sign(i_div_rsp.mag, r_s2v[63]);
                end
            end
            vma_pkg::ST_MUL_UU: begin
                if (i_mul_rsp.done) begin
                    r_uu <= i_mul_rsp.mag;
                end
            end
            default: begin
            end
        endcase
        if (w_load) begin
            r_density     <= w_dens;
            r_momentum    <= w_mom;
            r_temperature <= w_tout;
            r_saturated   <= w_fin_sat;
        end
    end

endmodule

// ===== src/velocity_moment_accumulator.sv =====
// Velocity moment accumulator. Samples are taken one per cycle, unless the pipe
// holds, into a four-stage front pipeline that forms f*v and f*v*v and updates three
// saturating 64-bit sums; a sample flagged row_end hands the row's sums to a
// two-entry queue. A back end then works on one row at a time: three scalings by dv
// and the u*u product on a shared multiplier of four 32x32 partial products, and two
// restoring divisions on a one-bit-per-cycle divider. Rows that arrive faster than
// the back end finishes them fill the queue and then hold the sample input until a
// row drains.
module velocity_moment_accumulator #(
    parameter int unsigned FRAC_BITS   = vma_pkg::FRAC_BITS,
    parameter int unsigned QUEUE_DEPTH = vma_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    vma_in_if.sink      i_in,
    vma_out_if.source   o_out
);

    logic               r_dv;
    logic [31:0]        r_dv_reg;
    logic               w_q_push;
    logic               w_q_ready;
    logic               w_q_valid;
    logic               w_q_pop;
    vma_pkg::t_sums     w_q_wdata;
    vma_pkg::t_sums     w_q_rdata;
    vma_pkg::t_mul_req  w_mul_req;
    vma_pkg::t_unit_rsp w_mul_rsp;
    vma_pkg::t_div_req  w_div_req;
    vma_pkg::t_unit_rsp w_div_rsp;

    // holds dv and marks that dv has been written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_reg <= vma_pkg::DV_RESET;
            r_dv     <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_dv_reg <= i_cfg_wr_data;
            r_dv     <= 1'b1;
        end
    end

    vma_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (w_q_ready),
        .o_q_push  (w_q_push),
        .o_q_data  (w_q_wdata)
    );

    vma_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_data  (w_q_rdata),
        .i_pop   (w_q_pop)
    );

    vma_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    vma_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    vma_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dv      (r_dv_reg),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_rdata),
        .o_q_pop   (w_q_pop),
        .o_mul_req (w_mul_req),
        .i_mul_rsp (w_mul_rsp),
        .o_div_req (w_div_req),
        .i_div_rsp (w_div_rsp),
        .o_out     (o_out)
    );

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> w_q_ready)
        else $error("row pushed into a full queue");

    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("row popped from an empty queue");

    a_out_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.density != '0) && (o_out.temperature != '0))
        else $error("density or temperature below one lsb");

    a_cfg_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> r_dv && (r_dv_reg == $past(i_cfg_wr_data)))
        else $error("dv register missed a write");

endmodule
